### sv/grid_maze_dfs_path_finder_defines.svh
// Assertion macros shared by the maze search RTL.
// All macros sample on clk and are disabled while arst_n is low.
`ifndef GRID_MAZE_DFS_PATH_FINDER_DEFINES_SVH
`define GRID_MAZE_DFS_PATH_FINDER_DEFINES_SVH

// Condition must hold at every edge
`define GMDFS_ASSERT_NOW(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define GMDFS_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define GMDFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/gmdfs_pkg.sv
`timescale 1ns / 1ps

package gmdfs_pkg;

	// Grid geometry; cells are indexed as row*8 + col
	localparam int GRID_ROWS  = 8;
	localparam int GRID_COLS  = 8;
	localparam int CELL_SLOTS = 64;
	localparam int IDX_W      = 6;
	localparam int SP_W       = 7;

	// Command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_RUN  = 1'b1;

	typedef logic [IDX_W-1:0] cell_idx_t;

	// Search sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_TEST,
		ST_EXPAND,
		ST_MISS,
		ST_EMIT,
		ST_PREV
	} state_t;

	// Neighbour visiting order
	typedef enum logic [1:0] {
		DIR_RIGHT,
		DIR_DOWN,
		DIR_LEFT,
		DIR_UP
	} dir_t;

	// Neighbour unit result
	typedef struct packed {
		logic      inb;
		cell_idx_t idx;
	} neigh_t;

endpackage

### sv/gmdfs_neigh.sv
`timescale 1ns / 1ps

// Neighbour address unit: one direction per cycle, with a grid bounds check.
module gmdfs_neigh import gmdfs_pkg::*; (
	input  cell_idx_t cur,
	input  dir_t      dir,
	output neigh_t    nb
);

	logic [2:0] row;
	logic [2:0] col;
	logic [3:0] row_nx;
	logic [3:0] col_nx;

	assign row    = cur[5:3];
	assign col    = cur[2:0];
	assign row_nx = {1'b0, row} + 4'd1;
	assign col_nx = {1'b0, col} + 4'd1;

	always_comb begin
		nb.inb = 1'b0;
		nb.idx = cur;
		case (dir)
			DIR_RIGHT: begin
				nb.inb = col_nx < 4'(GRID_COLS);
				nb.idx = {row, col_nx[2:0]};
			end
			DIR_DOWN: begin
				nb.inb = row_nx < 4'(GRID_ROWS);
				nb.idx = {row_nx[2:0], col};
			end
			DIR_LEFT: begin
				nb.inb = col != 3'd0;
				nb.idx = {row, col - 3'd1};
			end
			DIR_UP: begin
				nb.inb = row != 3'd0;
				nb.idx = {row - 3'd1, col};
			end
			default: begin
				nb.inb = 1'b0;
				nb.idx = cur;
			end
		endcase
	end

endmodule

### sv/grid_maze_dfs_path_finder.sv
// Depth-first maze search over an 8 x 8 grid of open and wall cells. A load
// transaction (cmd 0) writes one wall bit; loads outside the grid are dropped.
// A run transaction (cmd 1) searches from (0,0) to the bottom-right cell with
// a 64-entry cell stack and then returns the path goal first, one result per
// cell, with last set on the start cell; if the goal is not reached, a single
// result with found 0 and last 1 is returned. The block stalls new
// transactions from the run until the final result is taken. Run steps: the
// accepting cycle seeds the stack; each expanded cell then takes a stack pop,
// a top-of-stack check and one neighbour direction per cycle through the
// shared neighbour unit; the goal is popped by a stack pop and a check, and
// an empty stack is caught by the pop step before the single miss result.
// Each path cell is then shown until it is taken, with a predecessor memory
// read between cells. The wall map is cleared by reset; the visited map is
// cleared at the start of each run.
`timescale 1ns / 1ps

`include "grid_maze_dfs_path_finder_defines.svh"

module grid_maze_dfs_path_finder import gmdfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       cmd,
	input  logic [2:0] cell_row,
	input  logic [2:0] cell_col,
	input  logic       blocked,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       found,
	output logic [2:0] path_row,
	output logic [2:0] path_col,
	output logic       last
);

	state_t state_q, state_nx;
	dir_t   dir_q;

	logic [CELL_SLOTS-1:0] wall_q;
	logic [CELL_SLOTS-1:0] visited_q;
	logic [SP_W-1:0]       sp_q;
	cell_idx_t             cur_q;

	cell_idx_t stack_mem_q [CELL_SLOTS];
	cell_idx_t prev_mem_q  [CELL_SLOTS];
	cell_idx_t stk_rd_q;
	cell_idx_t prev_rd_q;

	neigh_t nb;
	logic   item_acc;
	logic   result_acc;
	logic   load_ok;
	logic   enter;
	logic   at_goal;
	logic   at_start;

	cell_idx_t stk_raddr;
	logic      stk_re;

	gmdfs_neigh u_neigh (
		.cur (cur_q),
		.dir (dir_q),
		.nb  (nb)
	);

	assign item_acc   = item_valid && !item_stall;
	assign result_acc = result_valid && !result_stall;
	assign load_ok    = ({1'b0, cell_row} < 4'(GRID_ROWS)) &&
		({1'b0, cell_col} < 4'(GRID_COLS));
	assign enter      = nb.inb && !wall_q[nb.idx] && !visited_q[nb.idx];
	assign at_goal    = ({1'b0, stk_rd_q[5:3]} == 4'(GRID_ROWS - 1)) &&
		({1'b0, stk_rd_q[2:0]} == 4'(GRID_COLS - 1));
	assign at_start   = cur_q == '0;
	assign stk_raddr  = 6'(sp_q - 7'd1);
	assign stk_re     = (state_q == ST_POP) && (sp_q != '0);

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_acc && cmd == CMD_RUN) state_nx = ST_POP;
			end
			ST_POP: begin
				state_nx = (sp_q == '0) ? ST_MISS : ST_TEST;
			end
			ST_TEST: begin
				state_nx = at_goal ? ST_EMIT : ST_EXPAND;
			end
			ST_EXPAND: begin
				if (dir_q == DIR_UP) state_nx = ST_POP;
			end
			ST_MISS: begin
				if (result_acc) state_nx = ST_IDLE;
			end
			ST_EMIT: begin
				if (result_acc) state_nx = at_start ? ST_IDLE : ST_PREV;
			end
			ST_PREV: begin
				state_nx = ST_EMIT;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		item_stall   = state_q != ST_IDLE;
		result_valid = 1'b0;
		found        = 1'b0;
		path_row     = 3'd0;
		path_col     = 3'd0;
		last         = 1'b0;
		case (state_q)
			ST_MISS: begin
				result_valid = 1'b1;
				last         = 1'b1;
			end
			ST_EMIT: begin
				result_valid = 1'b1;
				found        = 1'b1;
				path_row     = cur_q[5:3];
				path_col     = cur_q[2:0];
				last         = at_start;
			end
			default: begin
				result_valid = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			dir_q     <= DIR_RIGHT;
			sp_q      <= '0;
			wall_q    <= '0;
			visited_q <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				ST_IDLE: begin
					if (item_acc && cmd == CMD_LOAD && load_ok)
						wall_q[{cell_row, cell_col}] <= blocked;
					if (item_acc && cmd == CMD_RUN) begin
						visited_q <= CELL_SLOTS'(1);
						sp_q      <= 7'd1;
					end
				end
				ST_POP: begin
					if (sp_q != '0) sp_q <= sp_q - 7'd1;
				end
				ST_TEST: begin
					dir_q <= DIR_RIGHT;
				end
				ST_EXPAND: begin
					dir_q <= dir_t'(dir_q + 2'd1);
					if (enter) begin
						visited_q[nb.idx] <= 1'b1;
						if (sp_q < 7'(CELL_SLOTS)) sp_q <= sp_q + 7'd1;
					end
				end
				default: begin
					dir_q <= dir_q;
				end
			endcase
		end
	end

	// Current cell
	always_ff @(posedge clk) begin
		if (state_q == ST_TEST) cur_q <= stk_rd_q;
		else if (state_q == ST_PREV) cur_q <= prev_rd_q;
	end

	// Cell stack memory
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_acc && cmd == CMD_RUN)
			stack_mem_q[0] <= '0;
		else if (state_q == ST_EXPAND && enter && sp_q < 7'(CELL_SLOTS))
			stack_mem_q[sp_q[5:0]] <= nb.idx;
		if (stk_re) stk_rd_q <= stack_mem_q[stk_raddr];
	end

	// Predecessor memory
	always_ff @(posedge clk) begin
		if (state_q == ST_EXPAND && enter) prev_mem_q[nb.idx] <= cur_q;
		if (state_q == ST_EMIT && result_acc) prev_rd_q <= prev_mem_q[cur_q];
	end

	`GMDFS_ASSERT_NOW(a_result_blocks_items, !result_valid || item_stall, "item accepted during result")
	`GMDFS_ASSERT_NOW(a_stack_bound, sp_q <= 7'(CELL_SLOTS), "stack pointer past depth")
	`GMDFS_ASSERT_IMPLY(a_path_ends_at_start, result_valid && found && last, path_row == 3'd0 && path_col == 3'd0, "path did not end at start")
	`GMDFS_ASSERT_NEXT(a_done_goes_idle, result_valid && !result_stall && last, !item_stall && !result_valid, "no return to idle after final result")

endmodule

### sim/grid_maze_dfs_path_finder_test.sv
`timescale 1ns / 1ps

module grid_maze_dfs_path_finder_test;
	import gmdfs_pkg::*;

	// One input transaction
	typedef struct packed {
		logic       cmd;
		logic [2:0] row;
		logic [2:0] col;
		logic       blocked;
	} maze_item_t;

	// One path result
	typedef struct packed {
		logic       found;
		logic [2:0] row;
		logic [2:0] col;
		logic       last;
	} path_step_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	logic       cmd = CMD_LOAD;
	logic [2:0] cell_row = 3'd0;
	logic [2:0] cell_col = 3'd0;
	logic       blocked = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic       found;
	logic [2:0] path_row;
	logic [2:0] path_col;
	logic       last;

	// Shadow of the block state for path prediction
	bit               maze_walls [CELL_SLOTS];
	bit               seen_cells [CELL_SLOTS];
	logic [6:0]       came_from  [CELL_SLOTS];
	logic [IDX_W-1:0] dfs_stack  [CELL_SLOTS];
	logic [SP_W-1:0]  dfs_depth;

	maze_item_t pending_items[$];
	maze_item_t item_on_bus;
	path_step_t expected_path[$];
	int         errors = 0;
	int         cycle_count = 0;
	int         items_made = 0;

	grid_maze_dfs_path_finder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.cmd          (cmd),
		.cell_row     (cell_row),
		.cell_col     (cell_col),
		.blocked      (blocked),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.found        (found),
		.path_row     (path_row),
		.path_col     (path_col),
		.last         (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Random idling, with a quiet window where both sides run flat out
	function automatic bit take_break();
		if (cycle_count >= 3000 && cycle_count < 9000)
			return 1'b0;
		return $urandom_range(99) < 38;
	endfunction

	// Mark a neighbor visited and push it if open and not yet seen
	function automatic void enter_if_open(int r, int c, logic [IDX_W-1:0] from);
		int k;
		k = r * GRID_COLS + c;
		if (!maze_walls[k] && !seen_cells[k]) begin
			seen_cells[k] = 1'b1;
			came_from[k] = {1'b1, from};
			if (dfs_depth < CELL_SLOTS) begin
				dfs_stack[dfs_depth[IDX_W-1:0]] = k[IDX_W-1:0];
				dfs_depth = dfs_depth + 1'b1;
			end
		end
	endfunction

	// Apply one accepted transaction and queue the path results it causes
	task automatic trace_maze(input maze_item_t it);
		logic [IDX_W-1:0] cur;
		logic [6:0]       p;
		int               r;
		int               c;
		int               n;
		bit               reached;
		bit               end_flag;
		if (it.cmd == CMD_LOAD) begin
			if (it.row < GRID_ROWS && it.col < GRID_COLS)
				maze_walls[{it.row, it.col}] = it.blocked;
			return;
		end
		foreach (seen_cells[i]) seen_cells[i] = 1'b0;
		seen_cells[0] = 1'b1;
		came_from[0] = '0;
		dfs_stack[0] = '0;
		dfs_depth = SP_W'(1);
		reached = 1'b0;
		cur = '0;
		while (dfs_depth > 0) begin
			dfs_depth = dfs_depth - 1'b1;
			cur = dfs_stack[dfs_depth[IDX_W-1:0]];
			r = int'(cur[5:3]);
			c = int'(cur[2:0]);
			if (r == GRID_ROWS - 1 && c == GRID_COLS - 1) begin
				reached = 1'b1;
				break;
			end
			if (c + 1 < GRID_COLS) enter_if_open(r, c + 1, cur);
			if (r + 1 < GRID_ROWS) enter_if_open(r + 1, c, cur);
			if (c >= 1) enter_if_open(r, c - 1, cur);
			if (r >= 1) enter_if_open(r - 1, c, cur);
		end
		if (!reached) begin
			expected_path.push_back('{1'b0, 3'd0, 3'd0, 1'b1});
			return;
		end
		// Walk predecessors from the goal back to the start
		n = 0;
		while (n < CELL_SLOTS) begin
			p = came_from[cur];
			end_flag = !p[6] || n == CELL_SLOTS - 1;
			expected_path.push_back('{1'b1, cur[5:3], cur[2:0], end_flag});
			n++;
			if (end_flag)
				break;
			cur = p[IDX_W-1:0];
		end
	endtask

	// Driver: present pending transactions, hold while stalled
	always @(posedge clk) begin : drive_items
		maze_item_t nxt;
		if (arst_n) begin
			if (item_valid && !item_stall)
				trace_maze(item_on_bus);
			if (!item_valid || !item_stall) begin
				if (pending_items.size() > 0 && !take_break()) begin
					nxt = pending_items.pop_front();
					item_on_bus = nxt;
					item_valid <= 1'b1;
					cmd <= nxt.cmd;
					cell_row <= nxt.row;
					cell_col <= nxt.col;
					blocked <= nxt.blocked;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result against the oldest prediction
	always @(posedge clk) begin : check_results
		path_step_t want;
		path_step_t got;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				got = '{found, path_row, path_col, last};
				if (expected_path.size() == 0) begin
					$display("%0t: unexpected result found=%0d row=%0d col=%0d last=%0d",
						$time, got.found, got.row, got.col, got.last);
					errors++;
				end else begin
					want = expected_path.pop_front();
					if (got !== want) begin
						$display("%0t: path mismatch expected found=%0d row=%0d col=%0d last=%0d, actual found=%0d row=%0d col=%0d last=%0d",
							$time, want.found, want.row, want.col, want.last,
							got.found, got.row, got.col, got.last);
						errors++;
					end
				end
			end
			result_stall <= take_break();
		end
	end

	task automatic add_load(input int r, input int c, input bit b);
		pending_items.push_back('{CMD_LOAD, r[2:0], c[2:0], b});
		items_made++;
	endtask

	// Run with random don't-care fields
	task automatic add_run();
		pending_items.push_back('{CMD_RUN, 3'($urandom_range(7)), 3'($urandom_range(7)),
			1'($urandom_range(1))});
		items_made++;
	endtask

	// Stimulus and end of run
	initial begin : stimulus
		int kind;
		int cnt;
		int r;
		int c;

		// Directed: empty grid, blocked goal, walled start, boxed-in start, boxed-in goal
		pending_items.push_back('{CMD_RUN, 3'd0, 3'd0, 1'b0});
		add_load(7, 7, 1);
		add_run();
		add_load(7, 7, 0);
		add_load(0, 0, 1);
		add_run();
		add_load(0, 0, 0);
		add_load(0, 1, 1);
		add_load(1, 0, 1);
		add_run();
		add_load(0, 1, 0);
		pending_items.push_back('{CMD_RUN, 3'd7, 3'd7, 1'b1});
		add_load(1, 0, 0);
		add_load(7, 0, 1);
		add_load(0, 7, 1);
		add_load(6, 7, 1);
		add_run();
		add_load(7, 6, 1);
		add_run();
		add_load(7, 0, 0);
		add_load(0, 7, 0);
		add_load(6, 7, 0);
		add_load(7, 6, 0);
		items_made += 2;

		// Random: wall scatter, carved corridors, dead ends and noise
		while (items_made < 275) begin
			kind = $urandom_range(99);
			if (kind < 40) begin
				cnt = $urandom_range(8, 2);
				repeat (cnt)
					add_load($urandom_range(7), $urandom_range(7), $urandom_range(99) < 40);
				add_run();
			end else if (kind < 65) begin
				// Open a random monotone corridor from start to goal
				r = 0;
				c = 0;
				add_load(0, 0, 0);
				while (r != GRID_ROWS - 1 || c != GRID_COLS - 1) begin
					if (c == GRID_COLS - 1 || (r != GRID_ROWS - 1 && $urandom_range(1)))
						r++;
					else
						c++;
					add_load(r, c, 0);
				end
				add_run();
			end else if (kind < 80) begin
				// Close off the goal or the start
				if ($urandom_range(1)) begin
					add_load(7, 7, 1);
					add_run();
					add_load(7, 7, 0);
				end else begin
					add_load(0, 1, 1);
					add_load(1, 0, 1);
					add_run();
					add_load(0, 1, 1'($urandom_range(1)));
					add_load(1, 0, 0);
				end
			end else begin
				cnt = $urandom_range(4, 1);
				repeat (cnt) begin
					if ($urandom_range(1))
						add_run();
					else
						add_load($urandom_range(7), $urandom_range(7),
							1'($urandom_range(1)));
				end
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || item_valid)
			@(posedge clk);
		while (expected_path.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (errors == 0 && expected_path.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
